// ===== hw/rtl/harrp_pkg.sv =====
// Shared types and constants of the health-aware round-robin picker.
// Used by harrp_ctrl, harrp_dp and the top level; depends on nothing.
package harrp_pkg;

  localparam int unsigned MAX_SERVERS_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF  = 32;

  localparam int unsigned SC_W     = 5;   // server_count
  localparam int unsigned CD_W     = 31;  // cooldown_ms
  localparam int unsigned MF_W     = 8;   // max_failures / failure count
  localparam int unsigned SIDX_W   = 4;   // server_index and picked_index fields
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned CFG_DW   = 31;

  localparam logic [CFG_IW-1:0] REG_SERVER_COUNT = 2'd0;
  localparam logic [CFG_IW-1:0] REG_COOLDOWN_MS  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_MAX_FAILURES = 2'd2;

  localparam logic [SC_W-1:0] SERVER_COUNT_RST = 5'd16;
  localparam logic [CD_W-1:0] COOLDOWN_MS_RST  = 31'd10000;
  localparam logic [MF_W-1:0] MAX_FAILURES_RST = 8'd3;
  localparam logic [MF_W-1:0] FAIL_SAT         = 8'hFF;

  typedef enum logic [1:0] {
    KIND_PICK    = 2'd0,
    KIND_FAILURE = 2'd1,
    KIND_SUCCESS = 2'd2,
    KIND_TICK    = 2'd3
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // transaction accepted this cycle
    logic cnt_rd;     // read failure count of the reported entry
    logic rpt_apply;  // update the reported entry
    logic scan_rd;    // read dead stamp of the scan entry
    logic scan_eval;  // judge the scan entry, advance pointer
    logic out_load;   // move result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic n_zero;     // empty pool
    logic scan_hit;   // scan entry usable
    logic scan_last;  // scan entry is the last one to visit
    logic out_free;   // output register can take a result
  } dp_stat_t;

endpackage

// ===== hw/rtl/harrp_ctrl.sv =====
// Sequencer of the picker: walks each report through a count read and an
// entry update and each pick through the scan. Depends on harrp_pkg.
module harrp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  harrp_pkg::kind_e    in_kind_i,
  input  harrp_pkg::dp_stat_t stat_i,
  output logic                in_ready_o,
  output harrp_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT_RD,
    S_RPT,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (in_kind_i)
            harrp_pkg::KIND_PICK:    state_d = stat_i.n_zero ? S_DONE : S_SCAN_RD;
            harrp_pkg::KIND_FAILURE: state_d = S_CNT_RD;
            harrp_pkg::KIND_SUCCESS: state_d = S_CNT_RD;
            default:                 state_d = S_DONE;
          endcase
        end
      end
      S_CNT_RD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = S_RPT;
      end
      S_RPT: begin
        cmd_o.rpt_apply = 1'b1;
        state_d         = S_DONE;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd_o.scan_eval = 1'b1;
        state_d         = (stat_i.scan_hit || stat_i.scan_last) ? S_DONE : S_SCAN_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/harrp_dp.sv =====
// Datapath of the picker: configuration, server table, clock, pointer,
// scan registers and output register. Depends on harrp_pkg.
module harrp_dp #(
  parameter int unsigned MAX_SERVERS = harrp_pkg::MAX_SERVERS_DEF,
  parameter int unsigned TIME_WIDTH  = harrp_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [harrp_pkg::CFG_IW-1:0]      cfg_index_i,
  input  logic [harrp_pkg::CFG_DW-1:0]      cfg_data_i,
  // input item
  input  harrp_pkg::kind_e                  in_kind_i,
  input  logic [harrp_pkg::SIDX_W-1:0]      in_sidx_i,
  // control
  input  harrp_pkg::dp_cmd_t                cmd_i,
  output harrp_pkg::dp_stat_t               stat_o,
  // result
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              out_picked_valid_o,
  output logic [harrp_pkg::SIDX_W-1:0]      out_picked_index_o,
  output logic                              out_revived_o
);

  localparam int unsigned IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned NW    = (IDX_W + 1 > harrp_pkg::SC_W) ? IDX_W + 1 : harrp_pkg::SC_W;
  localparam int unsigned CMP_W = (TIME_WIDTH > harrp_pkg::CD_W) ? TIME_WIDTH : harrp_pkg::CD_W;
  localparam int unsigned MF_W  = harrp_pkg::MF_W;

  // configuration registers
  logic [harrp_pkg::SC_W-1:0] server_count_q;
  logic [harrp_pkg::CD_W-1:0] cooldown_q;
  logic [MF_W-1:0]            max_fail_q;

  // control state
  logic [IDX_W-1:0]       rr_q, rr_d;
  logic [TIME_WIDTH-1:0]  now_q, now_d;
  logic [MAX_SERVERS-1:0] alive_q, alive_d;
  logic [MAX_SERVERS-1:0] cnt_vld_q, cnt_vld_d;   // count entry written since cleared
  logic [IDX_W-1:0]       cur_q, cur_d;
  logic [NW-1:0]          step_q, step_d;
  logic                   out_vld_q, out_vld_d;
  // kind of the held item
  harrp_pkg::kind_e       kind_q;

  // payload registers
  logic [harrp_pkg::SIDX_W-1:0] idx_q;
  logic [MF_W-1:0]              cnt_rd_q;
  logic [TIME_WIDTH-1:0]        stamp_rd_q;
  logic                         res_pv_q, res_rv_q;
  logic [harrp_pkg::SIDX_W-1:0] res_pi_q;
  logic                         out_pv_q, out_rv_q;
  logic [harrp_pkg::SIDX_W-1:0] out_pi_q;

  // memories
  logic [MF_W-1:0]       cnt_mem   [MAX_SERVERS];
  logic [TIME_WIDTH-1:0] stamp_mem [MAX_SERVERS];

  logic [NW-1:0]         n_act;
  logic [IDX_W-1:0]      rep_idx;
  logic                  rep_ok;
  logic [IDX_W-1:0]      tbl_addr;
  logic                  tbl_alive;
  logic [MF_W-1:0]       cnt_cur;
  logic [MF_W-1:0]       cnt_new;
  logic                  kill;
  logic                  cnt_we;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  expired;
  logic [NW-1:0]         cur_inc;
  logic [IDX_W-1:0]      cur_nxt;
  logic [IDX_W-1:0]      cur_start;

  assign n_act = (NW'(server_count_q) > NW'(MAX_SERVERS)) ? NW'(MAX_SERVERS)
                                                           : NW'(server_count_q);
  assign rep_idx = IDX_W'(idx_q);
  assign rep_ok  = NW'(idx_q) < n_act;

  // one table read port, shared by reports and the scan
  assign tbl_addr  = cmd_i.scan_eval ? cur_q : rep_idx;
  assign tbl_alive = alive_q[tbl_addr];

  assign cnt_cur = cnt_vld_q[tbl_addr] ? cnt_rd_q : '0;
  assign cnt_new = (cnt_cur == harrp_pkg::FAIL_SAT) ? cnt_cur : cnt_cur + 1'b1;
  assign kill    = (cnt_new >= max_fail_q) && tbl_alive;
  assign cnt_we  = cmd_i.rpt_apply && rep_ok && (kind_q == harrp_pkg::KIND_FAILURE);

  // wrapping elapsed time against cooldown
  assign elapsed = now_q - stamp_rd_q;
  assign expired = CMP_W'(elapsed) >= CMP_W'(cooldown_q);

  assign cur_inc   = NW'(cur_q) + 1'b1;
  assign cur_nxt   = (cur_inc >= n_act) ? '0 : IDX_W'(cur_inc);
  assign cur_start = (NW'(rr_q) < n_act) ? rr_q : '0;

  assign stat_o.n_zero    = (n_act == '0);
  assign stat_o.scan_hit  = tbl_alive || expired;
  assign stat_o.scan_last = (step_q + 1'b1) == n_act;
  assign stat_o.out_free  = !out_vld_q || out_ready_i;

  always_comb begin
    rr_d      = rr_q;
    now_d     = now_q;
    alive_d   = alive_q;
    cnt_vld_d = cnt_vld_q;
    cur_d     = cur_q;
    step_d    = step_q;
    out_vld_d = out_vld_q;

    if (cmd_i.load) begin
      cur_d  = cur_start;
      step_d = '0;
      if (in_kind_i == harrp_pkg::KIND_TICK) begin
        now_d = now_q + 1'b1;
      end
    end

    if (cmd_i.rpt_apply && rep_ok) begin
      if (kind_q == harrp_pkg::KIND_FAILURE) begin
        cnt_vld_d[rep_idx] = 1'b1;
        if (kill) begin
          alive_d[rep_idx] = 1'b0;
        end
      end else if (cnt_cur != '0) begin
        cnt_vld_d[rep_idx] = 1'b0;
        alive_d[rep_idx]   = 1'b1;
      end
    end

    if (cmd_i.scan_eval) begin
      rr_d   = cur_nxt;
      cur_d  = cur_nxt;
      step_d = step_q + 1'b1;
      if (!tbl_alive && expired) begin
        alive_d[cur_q]   = 1'b1;
        cnt_vld_d[cur_q] = 1'b0;
      end
    end

    if (cmd_i.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_count_q <= harrp_pkg::SERVER_COUNT_RST;
      cooldown_q     <= harrp_pkg::COOLDOWN_MS_RST;
      max_fail_q     <= harrp_pkg::MAX_FAILURES_RST;
      rr_q           <= '0;
      now_q          <= '0;
      alive_q        <= '1;
      cnt_vld_q      <= '0;
      cur_q          <= '0;
      step_q         <= '0;
      out_vld_q      <= 1'b0;
      kind_q         <= harrp_pkg::KIND_PICK;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          harrp_pkg::REG_SERVER_COUNT: server_count_q <= cfg_data_i[harrp_pkg::SC_W-1:0];
          harrp_pkg::REG_COOLDOWN_MS:  cooldown_q     <= cfg_data_i;
          harrp_pkg::REG_MAX_FAILURES: max_fail_q     <= cfg_data_i[MF_W-1:0];
          default: ;
        endcase
      end
      rr_q      <= rr_d;
      now_q     <= now_d;
      alive_q   <= alive_d;
      cnt_vld_q <= cnt_vld_d;
      cur_q     <= cur_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
      if (cmd_i.load) begin
        kind_q <= in_kind_i;
      end
    end
  end

  // payload and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q    <= in_sidx_i;
      res_pv_q <= 1'b0;
      res_pi_q <= '0;
      res_rv_q <= 1'b0;
    end
    if (cmd_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[rep_idx];
    end
    if (cnt_we) begin
      cnt_mem[rep_idx] <= cnt_new;
      if (kill) begin
        stamp_mem[rep_idx] <= now_q;
      end
    end
    if (cmd_i.scan_rd) begin
      stamp_rd_q <= stamp_mem[cur_q];
    end
    if (cmd_i.scan_eval && (tbl_alive || expired)) begin
      res_pv_q <= 1'b1;
      res_pi_q <= harrp_pkg::SIDX_W'(cur_q);
      res_rv_q <= !tbl_alive;
    end
    if (cmd_i.out_load) begin
      out_pv_q <= res_pv_q;
      out_pi_q <= res_pi_q;
      out_rv_q <= res_rv_q;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign out_picked_valid_o = out_pv_q;
  assign out_picked_index_o = out_pi_q;
  assign out_revived_o      = out_rv_q;

endmodule

// ===== hw/rtl/health_aware_round_robin_picker_unit.sv =====
// Health-aware round-robin server picker, top level.
// Instantiates harrp_ctrl and harrp_dp; depends on harrp_pkg.
//
// Input stream (s_axis): one transaction per request. tuser carries the kind
// (pick, failure report, success report, millisecond tick), tdata the server
// index for reports. Output stream (m_axis): exactly one result per request;
// tuser says whether a server was picked and whether the pick revived it,
// tdata holds the picked index (zero when none). Non-pick requests return an
// all-zero result.
// Configuration: cfg_valid_i/cfg_ready_o write channel, always ready; write
// only while no request is in flight.
// Timing: one request at a time. A tick or an empty-pool pick goes straight
// to the output register; a failure or success report first reads the failure
// count, then updates the entry; a pick visits up to the active server count
// of entries, each costing a dead-stamp memory read and an evaluation. The
// next request is taken the cycle after the result is loaded, even if the
// receiver has not yet taken it.
// Receiver stall: the result holds in the output register; a finished request
// then waits until the register frees up.
// Reset: all servers alive, counts, clock and pointer zero, registers at their
// defaults; usable as soon as reset is released, no clearing pass.
module health_aware_round_robin_picker_unit #(
  parameter int unsigned MAX_SERVERS = harrp_pkg::MAX_SERVERS_DEF,
  parameter int unsigned TIME_WIDTH  = harrp_pkg::TIME_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [3:0] server_index, [7:4] zero
  input  logic [1:0]                   s_axis_tuser,  // [1:0] kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [3:0] picked_index, [7:4] zero
  output logic [1:0]                   m_axis_tuser,  // [0] picked_valid, [1] revived
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [harrp_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [harrp_pkg::CFG_DW-1:0] cfg_data_i
);

  harrp_pkg::dp_cmd_t           cmd;
  harrp_pkg::dp_stat_t          stat;
  harrp_pkg::kind_e             in_kind;
  logic                         pv, rv;
  logic [harrp_pkg::SIDX_W-1:0] pi;

  assign in_kind     = harrp_pkg::kind_e'(s_axis_tuser);
  assign cfg_ready_o = 1'b1;

  harrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (in_kind),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  harrp_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_kind_i          (in_kind),
    .in_sidx_i          (s_axis_tdata[harrp_pkg::SIDX_W-1:0]),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .out_picked_valid_o (pv),
    .out_picked_index_o (pi),
    .out_revived_o      (rv)
  );

  assign m_axis_tdata = {4'b0, pi};
  assign m_axis_tuser = {rv, pv};

endmodule

// ===== hw/rtl/harrp_checker.sv =====
// Port-level checks of the picker, bound to the top level.
// Depends on health_aware_round_robin_picker_unit port names.
module harrp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one request in flight: no back-to-back acceptance
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted while busy");

  // no pick means an all-zero result
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0 && !m_axis_tuser[1])
    else $error("empty result carries data");

  // padding stays zero on valid results
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:4] == 4'd0)
    else $error("result padding not zero");

endmodule

bind health_aware_round_robin_picker_unit harrp_checker u_harrp_checker (.*);

// ===== tb/health_aware_round_robin_picker_unit_tb.sv =====
// Self-checking testbench for health_aware_round_robin_picker_unit.
// Predicts every result from a local copy of the server table. Needs harrp_pkg.
module health_aware_round_robin_picker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 40;   // longer than the longest pick, which visits all 16 entries
  localparam logic [harrp_pkg::CD_W-1:0] COOLDOWN_MAX = '1;

  typedef struct packed {
    logic                         revived;
    logic                         picked;
    logic [harrp_pkg::SIDX_W-1:0] index;
  } outcome_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata;
  logic [1:0]                   s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [7:0]                   m_axis_tdata;
  logic [1:0]                   m_axis_tuser;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [harrp_pkg::CFG_IW-1:0] cfg_index_i;
  logic [harrp_pkg::CFG_DW-1:0] cfg_data_i;

  // predicted server table and registers
  logic [harrp_pkg::SC_W-1:0]   cfg_servers;
  logic [harrp_pkg::CD_W-1:0]   cfg_cooldown;
  logic [harrp_pkg::MF_W-1:0]   cfg_max_fail;
  int unsigned                  rr_ptr;
  logic [31:0]                  clock_ms;
  logic                         alive [harrp_pkg::MAX_SERVERS_DEF];
  logic [harrp_pkg::MF_W-1:0]   fail_cnt [harrp_pkg::MAX_SERVERS_DEF];
  logic [31:0]                  dead_at [harrp_pkg::MAX_SERVERS_DEF];

  outcome_t                     outcomes_due[$];
  outcome_t                     due;
  int unsigned                  mismatches;
  int unsigned                  src_idle_pct;
  int unsigned                  dst_idle_pct;
  int unsigned                  hold_seq;

  health_aware_round_robin_picker_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [3:0] server_index, [7:4] zero
    .s_axis_tuser  (s_axis_tuser),   // [1:0] kind
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [3:0] picked_index, [7:4] zero
    .m_axis_tuser  (m_axis_tuser),   // [0] picked_valid, [1] revived
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned pool_size();
    return (cfg_servers > harrp_pkg::MAX_SERVERS_DEF) ? harrp_pkg::MAX_SERVERS_DEF
                                                      : int'(cfg_servers);
  endfunction

  task automatic reset_table();
    cfg_servers  = harrp_pkg::SERVER_COUNT_RST;
    cfg_cooldown = harrp_pkg::COOLDOWN_MS_RST;
    cfg_max_fail = harrp_pkg::MAX_FAILURES_RST;
    rr_ptr       = 0;
    clock_ms     = '0;
    for (int i = 0; i < harrp_pkg::MAX_SERVERS_DEF; i++) begin
      alive[i]    = 1'b1;
      fail_cnt[i] = '0;
      dead_at[i]  = '0;
    end
  endtask

  // Updates the server table for one request and returns the result it yields.
  function automatic outcome_t apply_request(harrp_pkg::kind_e k,
                                             logic [harrp_pkg::SIDX_W-1:0] sidx);
    outcome_t    res;
    int unsigned n;
    int unsigned cur;
    int unsigned slot;
    logic [31:0] elapsed;
    res = '0;
    n = pool_size();
    case (k)
      harrp_pkg::KIND_PICK: begin
        if (n != 0) begin
          cur = (rr_ptr < n) ? rr_ptr : 0;
          for (int step = 0; step < n; step++) begin
            slot = cur;
            cur = (cur + 1 >= n) ? 0 : cur + 1;
            rr_ptr = cur;
            elapsed = clock_ms - dead_at[slot];   // wraps mod 2^32
            if (alive[slot] || elapsed >= {1'b0, cfg_cooldown}) begin
              res.picked  = 1'b1;
              res.index   = harrp_pkg::SIDX_W'(slot);
              res.revived = !alive[slot];
              if (!alive[slot]) begin
                alive[slot]    = 1'b1;
                fail_cnt[slot] = '0;
              end
              break;
            end
          end
        end
      end
      harrp_pkg::KIND_FAILURE: begin
        if (sidx < n) begin
          if (fail_cnt[sidx] != harrp_pkg::FAIL_SAT) fail_cnt[sidx]++;
          if (fail_cnt[sidx] >= cfg_max_fail && alive[sidx]) begin
            alive[sidx]   = 1'b0;
            dead_at[sidx] = clock_ms;
          end
        end
      end
      harrp_pkg::KIND_SUCCESS: begin
        if (sidx < n && fail_cnt[sidx] != 0) begin
          fail_cnt[sidx] = '0;
          alive[sidx]    = 1'b1;
        end
      end
      harrp_pkg::KIND_TICK: clock_ms++;
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // receiver: random stalls, plus a long hold-off whenever hold_seq moves
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (outcomes_due.size() == 0) begin
        flag_mismatch("result with none outstanding", '0, {m_axis_tuser, m_axis_tdata});
      end else begin
        due = outcomes_due.pop_front();
        if (m_axis_tuser[0] !== due.picked)
          flag_mismatch("picked_valid", due.picked, m_axis_tuser[0]);
        if (m_axis_tuser[1] !== due.revived)
          flag_mismatch("revived", due.revived, m_axis_tuser[1]);
        if (m_axis_tdata !== {4'b0, due.index})
          flag_mismatch("picked_index", due.index, m_axis_tdata);
      end
    end
  end

  task automatic send_item(harrp_pkg::kind_e k, logic [harrp_pkg::SIDX_W-1:0] sidx);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {4'b0, sidx};
    do @(posedge clk_i); while (!s_axis_tready);
    outcomes_due.push_back(apply_request(k, sidx));
  endtask

  task automatic wait_idle();
    int unsigned spent;
    s_axis_tvalid <= 1'b0;
    spent = 0;
    while (outcomes_due.size() != 0 && spent < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spent++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [harrp_pkg::CFG_IW-1:0] idx,
                           logic [harrp_pkg::CFG_DW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      harrp_pkg::REG_SERVER_COUNT: cfg_servers  = val[harrp_pkg::SC_W-1:0];
      harrp_pkg::REG_COOLDOWN_MS:  cfg_cooldown = val[harrp_pkg::CD_W-1:0];
      harrp_pkg::REG_MAX_FAILURES: cfg_max_fail = val[harrp_pkg::MF_W-1:0];
      default: ;
    endcase
  endtask

  // writes all three registers once the block has gone quiet
  task automatic configure(logic [harrp_pkg::SC_W-1:0] servers,
                           logic [harrp_pkg::CD_W-1:0] cooldown,
                           logic [harrp_pkg::MF_W-1:0] max_fail);
    wait_idle();
    write_reg(harrp_pkg::REG_SERVER_COUNT, harrp_pkg::CFG_DW'(servers));
    write_reg(harrp_pkg::REG_COOLDOWN_MS, harrp_pkg::CFG_DW'(cooldown));
    write_reg(harrp_pkg::REG_MAX_FAILURES, harrp_pkg::CFG_DW'(max_fail));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_traffic(int unsigned budget);
    int unsigned sent;
    int unsigned roll;
    int unsigned run;
    int unsigned n;
    logic [harrp_pkg::SIDX_W-1:0] target;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(99);
      n = pool_size();
      // reports mostly land inside the pool, now and then anywhere
      if (n == 0 || $urandom_range(9) == 0) target = harrp_pkg::SIDX_W'($urandom_range(15));
      else target = harrp_pkg::SIDX_W'($urandom_range(n - 1));
      if (roll < 30) begin
        send_item(harrp_pkg::KIND_PICK, harrp_pkg::SIDX_W'($urandom_range(15)));
        sent++;
      end else if (roll < 55) begin
        run = $urandom_range(1, 4);
        repeat (run) send_item(harrp_pkg::KIND_TICK, harrp_pkg::SIDX_W'($urandom_range(15)));
        sent += run;
      end else if (roll < 63) begin
        send_item(harrp_pkg::KIND_SUCCESS, target);
        sent++;
      end else if (roll < 80) begin
        send_item(harrp_pkg::KIND_FAILURE, target);
        sent++;
      end else begin
        // a run of failures, capped at six: enough to take the server down when the limit is at most six
        run = (cfg_max_fail == 0) ? 1 : ((cfg_max_fail > 6) ? 6 : int'(cfg_max_fail));
        repeat (run) send_item(harrp_pkg::KIND_FAILURE, target);
        sent += run;
      end
    end
  endtask

  task automatic test_basic_kinds();
    send_item(harrp_pkg::KIND_PICK, 4'd0);
    send_item(harrp_pkg::KIND_PICK, 4'd15);
    send_item(harrp_pkg::KIND_TICK, 4'd15);
    send_item(harrp_pkg::KIND_SUCCESS, 4'd15);   // clean entry, no effect
    send_item(harrp_pkg::KIND_FAILURE, 4'd0);
    send_item(harrp_pkg::KIND_SUCCESS, 4'd0);
  endtask

  task automatic test_kill_and_revive();
    configure(5'd16, harrp_pkg::COOLDOWN_MS_RST, 8'd0);   // zero limit: first failure kills
    send_item(harrp_pkg::KIND_FAILURE, 4'd3);
    send_item(harrp_pkg::KIND_FAILURE, 4'd3);
    send_item(harrp_pkg::KIND_PICK, 4'd0);
    send_item(harrp_pkg::KIND_PICK, 4'd0);
    // shrink the pool below the pointer; zero cooldown revives on first visit
    configure(5'd4, '0, 8'd0);
    repeat (4) send_item(harrp_pkg::KIND_PICK, 4'd0);
  endtask

  task automatic test_pool_limits();
    configure(5'd0, '0, 8'd0);
    send_item(harrp_pkg::KIND_PICK, 4'd0);
    send_item(harrp_pkg::KIND_FAILURE, 4'd0);
    send_item(harrp_pkg::KIND_SUCCESS, 4'd0);
    configure(5'd1, COOLDOWN_MAX, 8'd1);
    send_item(harrp_pkg::KIND_FAILURE, 4'd0);
    send_item(harrp_pkg::KIND_PICK, 4'd0);        // nothing usable
    send_item(harrp_pkg::KIND_FAILURE, 4'd15);    // outside the pool
    configure(5'd31, COOLDOWN_MAX, 8'd1);
    send_item(harrp_pkg::KIND_PICK, 4'd0);
    configure(5'd31, 31'd3, 8'd1);
    repeat (3) send_item(harrp_pkg::KIND_TICK, 4'd0);
    send_item(harrp_pkg::KIND_PICK, 4'd0);
  endtask

  // 256 failures: a wrapping counter would read zero and ignore the success
  task automatic test_failure_saturation();
    logic [harrp_pkg::SIDX_W-1:0] victim;
    victim = harrp_pkg::SIDX_W'($urandom_range(15));
    src_idle_pct = 0;
    dst_idle_pct = 0;
    configure(5'd16, COOLDOWN_MAX, 8'd255);
    repeat (256) send_item(harrp_pkg::KIND_FAILURE, victim);
    send_item(harrp_pkg::KIND_SUCCESS, victim);
    repeat (16) send_item(harrp_pkg::KIND_PICK, harrp_pkg::SIDX_W'($urandom_range(15)));
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    configure(5'd9, 31'd5, 8'd2);
    hold_seq++;
    random_traffic(40);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    src_idle_pct = 29;
    dst_idle_pct = 68;
    configure(5'd16, 31'd20, 8'd2);
    random_traffic(100);
    src_idle_pct = 68;
    dst_idle_pct = 29;
    configure(5'd6, 31'd8, 8'd1);
    random_traffic(100);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    configure(5'd31, 31'd40, 8'd3);
    random_traffic(50);
    configure(5'd11, '0, 8'd0);
    random_traffic(50);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = harrp_pkg::KIND_PICK;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = harrp_pkg::REG_SERVER_COUNT;
    cfg_data_i    = '0;
    mismatches    = 0;
    hold_seq      = 0;
    src_idle_pct  = 29;
    dst_idle_pct  = 68;
    reset_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_kinds();
    test_kill_and_revive();
    test_pool_limits();
    test_random_traffic();
    test_failure_saturation();
    test_backpressure();

    wait_idle();
    mismatches += outcomes_due.size();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/harrp_pkg.sv
hw/rtl/harrp_ctrl.sv
hw/rtl/harrp_dp.sv
hw/rtl/health_aware_round_robin_picker_unit.sv
hw/rtl/harrp_checker.sv
tb/health_aware_round_robin_picker_unit_tb.sv
